@@ rtl/sva_pkg.sv @@
`default_nettype none
package sva_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF   = 16;

    localparam int ANGLE_W    = 16;
    localparam int ZW         = 24;
    localparam int FRAC_BITS  = 20;
    localparam int OUT_SHIFT  = 7;

    localparam logic signed [ZW-1:0] PI_FX      = 24'sd3294199;
    localparam logic signed [ZW-1:0] HALF_PI_FX = 24'sd1647099;

    // atan(2^-i) scaled by 2^20; beyond step 7 it rounds to 2^(20-i), and beyond step 20 it is zero
    function automatic logic signed [ZW-1:0] atan_step(input int i);
        logic signed [ZW-1:0] r;
        r = '0;
        case (i)
            0: r = 24'sd823550;
            1: r = 24'sd486170;
            2: r = 24'sd256879;
            3: r = 24'sd130396;
            4: r = 24'sd65451;
            5: r = 24'sd32757;
            6: r = 24'sd16383;
            7: r = 24'sd8192;
            default:
            begin
                if (i > FRAC_BITS)
                    r = '0;
                else
                    r = ZW'(24'd1 << (FRAC_BITS - i));
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/sva_front.sv @@
`default_nettype none
module sva_front #(
    parameter int COMPONENT_BITS = sva_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [COMPONENT_BITS-1:0]     a_x,
    input  wire logic signed [COMPONENT_BITS-1:0]     a_y,
    input  wire logic signed [COMPONENT_BITS-1:0]     a_z,
    input  wire logic signed [COMPONENT_BITS-1:0]     b_x,
    input  wire logic signed [COMPONENT_BITS-1:0]     b_y,
    input  wire logic signed [COMPONENT_BITS-1:0]     b_z,
    input  wire logic signed [COMPONENT_BITS-1:0]     axis_x,
    input  wire logic signed [COMPONENT_BITS-1:0]     axis_y,
    input  wire logic signed [COMPONENT_BITS-1:0]     axis_z,
    input  wire logic                                 axis_present,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [4*COMPONENT_BITS+1:0]               out_sq,
    output logic signed [2*COMPONENT_BITS+1:0]        out_d,
    output logic                                      out_neg
);
    localparam int N  = COMPONENT_BITS;
    localparam int PW = 2*N;
    localparam int CW = 2*N + 1;
    localparam int DW = 2*N + 2;
    localparam int SW = 4*N + 2;
    localparam int AW = CW + N;
    localparam int TW = AW + 2;

    logic fe;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [PW-1:0] p_reg [9];
    logic signed [N-1:0]  ax1_reg [3];
    logic                 pr1_reg;
    logic signed [CW-1:0] c_reg [3];
    logic signed [DW-1:0] d2_reg;
    logic signed [N-1:0]  ax2_reg [3];
    logic                 pr2_reg;
    logic [SW-1:0]        sq3_reg [3];
    logic signed [AW-1:0] ap3_reg [3];
    logic signed [DW-1:0] d3_reg;
    logic                 pr3_reg;
    logic [SW-1:0]        sq4_reg;
    logic signed [DW-1:0] d4_reg;
    logic                 neg4_reg;

    logic [CW-1:0]        cmag [3];
    logic signed [TW-1:0] adot;

    assign fe        = !v4_reg || out_ready;
    assign in_ready  = fe;
    assign out_valid = v4_reg;
    assign out_sq    = sq4_reg;
    assign out_d     = d4_reg;
    assign out_neg   = neg4_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            cmag[k] = c_reg[k][CW-1] ? CW'(-c_reg[k]) : CW'(c_reg[k]);
        adot = TW'(ap3_reg[0]) + TW'(ap3_reg[1]) + TW'(ap3_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (fe)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            // products for cross and dot
            p_reg[0] <= PW'(a_y) * PW'(b_z);
            p_reg[1] <= PW'(a_z) * PW'(b_y);
            p_reg[2] <= PW'(a_z) * PW'(b_x);
            p_reg[3] <= PW'(a_x) * PW'(b_z);
            p_reg[4] <= PW'(a_x) * PW'(b_y);
            p_reg[5] <= PW'(a_y) * PW'(b_x);
            p_reg[6] <= PW'(a_x) * PW'(b_x);
            p_reg[7] <= PW'(a_y) * PW'(b_y);
            p_reg[8] <= PW'(a_z) * PW'(b_z);
            ax1_reg[0] <= axis_x;
            ax1_reg[1] <= axis_y;
            ax1_reg[2] <= axis_z;
            pr1_reg    <= axis_present;

            for (int k = 0; k < 3; k++)
                c_reg[k] <= CW'(p_reg[2*k]) - CW'(p_reg[2*k+1]);
            d2_reg  <= DW'(p_reg[6]) + DW'(p_reg[7]) + DW'(p_reg[8]);
            ax2_reg <= ax1_reg;
            pr2_reg <= pr1_reg;

            for (int k = 0; k < 3; k++)
            begin
                sq3_reg[k] <= SW'(cmag[k]) * SW'(cmag[k]);
                ap3_reg[k] <= AW'(c_reg[k]) * AW'(ax2_reg[k]);
            end
            d3_reg  <= d2_reg;
            pr3_reg <= pr2_reg;

            sq4_reg  <= sq3_reg[0] + sq3_reg[1] + sq3_reg[2];
            d4_reg   <= d3_reg;
            neg4_reg <= pr3_reg && adot[TW-1];
        end
    end

endmodule
`default_nettype wire

@@ rtl/sva_queue.sv @@
`default_nettype none
module sva_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ rtl/sva_back.sv @@
`default_nettype none
module sva_back #(
    parameter int COMPONENT_BITS = sva_pkg::COMPONENT_BITS_DEF,
    parameter int CORDIC_STEPS   = sva_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [4*COMPONENT_BITS+1:0]          in_sq,
    input  wire logic signed [2*COMPONENT_BITS+1:0]   in_d,
    input  wire logic                                 in_neg,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [sva_pkg::ANGLE_W-1:0]        angle
);
    localparam int N  = COMPONENT_BITS;
    localparam int DW = 2*N + 2;
    localparam int SW = 4*N + 2;
    localparam int R  = 2*N + 1;
    localparam int RW = R + 2;
    localparam int XW = 2*N + 4;
    localparam int ZW = sva_pkg::ZW;
    localparam int CS = CORDIC_STEPS;
    localparam int AWD = sva_pkg::ANGLE_W;

    logic be;

    // square root stages
    logic                 sv_reg   [R];
    logic [SW-1:0]        sn_reg   [R];
    logic [R-1:0]         sroot_reg[R];
    logic [RW-1:0]        srem_reg [R];
    logic signed [DW-1:0] sd_reg   [R];
    logic                 sneg_reg [R];

    // pre-rotation stage
    logic                 pv_reg, pzero_reg, pdneg_reg, pneg_reg;
    logic signed [XW-1:0] px_reg, py_reg;
    logic signed [ZW-1:0] pz_reg;

    // rotation stages
    logic                 cv_reg   [CS];
    logic signed [XW-1:0] cx_reg   [CS];
    logic signed [XW-1:0] cy_reg   [CS];
    logic signed [ZW-1:0] cz_reg   [CS];
    logic                 czero_reg[CS];
    logic                 cdneg_reg[CS];
    logic                 cneg_reg [CS];

    logic                  ov_reg;
    logic signed [AWD-1:0] ang_reg;

    assign be        = !ov_reg || out_ready;
    assign in_ready  = be;
    assign out_valid = ov_reg;
    assign angle     = ang_reg;

    genvar k;
    generate
        for (k = 0; k < R; k++)
        begin : g_sqrt
            logic                 iv;
            logic [SW-1:0]        in_n;
            logic [R-1:0]         iroot;
            logic [RW-1:0]        irem;
            logic signed [DW-1:0] id;
            logic                 ineg;
            logic [RW-1:0]        shrem, trial;

            if (k == 0)
            begin : g_first
                assign iv    = in_valid;
                assign in_n  = in_sq;
                assign iroot = '0;
                assign irem  = '0;
                assign id    = in_d;
                assign ineg  = in_neg;
            end
            else
            begin : g_next
                assign iv    = sv_reg[k-1];
                assign in_n  = sn_reg[k-1];
                assign iroot = sroot_reg[k-1];
                assign irem  = srem_reg[k-1];
                assign id    = sd_reg[k-1];
                assign ineg  = sneg_reg[k-1];
            end

            assign shrem = {irem[RW-3:0], in_n[SW-1:SW-2]};
            assign trial = {iroot, 2'b01};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sv_reg[k] <= 1'b0;
                else if (be)
                    sv_reg[k] <= iv;
            end

            always_ff @(posedge clk)
            begin
                if (be)
                begin
                    sn_reg[k]  <= {in_n[SW-3:0], 2'b00};
                    sd_reg[k]  <= id;
                    sneg_reg[k] <= ineg;
                    if (shrem >= trial)
                    begin
                        srem_reg[k]  <= shrem - trial;
                        sroot_reg[k] <= {iroot[R-2:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg[k]  <= shrem;
                        sroot_reg[k] <= {iroot[R-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // pre-rotate a negative cosine term by a quarter turn
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (be)
            pv_reg <= sv_reg[R-1];
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            pzero_reg <= (sroot_reg[R-1] == '0);
            pdneg_reg <= sd_reg[R-1][DW-1];
            pneg_reg  <= sneg_reg[R-1];
            if (sd_reg[R-1][DW-1])
            begin
                px_reg <= $signed(XW'(sroot_reg[R-1]));
                py_reg <= XW'(-sd_reg[R-1]);
                pz_reg <= sva_pkg::HALF_PI_FX;
            end
            else
            begin
                px_reg <= XW'(sd_reg[R-1]);
                py_reg <= $signed(XW'(sroot_reg[R-1]));
                pz_reg <= '0;
            end
        end
    end

    generate
        for (k = 0; k < CS; k++)
        begin : g_rot
            logic                 iv, izero, idneg, ineg;
            logic signed [XW-1:0] ix, iy, xs, ys;
            logic signed [ZW-1:0] iz;

            if (k == 0)
            begin : g_first
                assign iv    = pv_reg;
                assign ix    = px_reg;
                assign iy    = py_reg;
                assign iz    = pz_reg;
                assign izero = pzero_reg;
                assign idneg = pdneg_reg;
                assign ineg  = pneg_reg;
            end
            else
            begin : g_next
                assign iv    = cv_reg[k-1];
                assign ix    = cx_reg[k-1];
                assign iy    = cy_reg[k-1];
                assign iz    = cz_reg[k-1];
                assign izero = czero_reg[k-1];
                assign idneg = cdneg_reg[k-1];
                assign ineg  = cneg_reg[k-1];
            end

            assign xs = ix >>> k;
            assign ys = iy >>> k;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    cv_reg[k] <= 1'b0;
                else if (be)
                    cv_reg[k] <= iv;
            end

            always_ff @(posedge clk)
            begin
                if (be)
                begin
                    czero_reg[k] <= izero;
                    cdneg_reg[k] <= idneg;
                    cneg_reg[k]  <= ineg;
                    if (!iy[XW-1])
                    begin
                        cx_reg[k] <= ix + ys;
                        cy_reg[k] <= iy - xs;
                        cz_reg[k] <= iz + sva_pkg::atan_step(k);
                    end
                    else
                    begin
                        cx_reg[k] <= ix - ys;
                        cy_reg[k] <= iy + xs;
                        cz_reg[k] <= iz - sva_pkg::atan_step(k);
                    end
                end
            end
        end
    endgenerate

    // resolve a zero cross length, clamp, truncate to Q3.13 and apply the axis sign
    logic signed [ZW-1:0]  zc;
    logic signed [AWD-1:0] mag;

    always_comb
    begin
        if (czero_reg[CS-1])
            zc = cdneg_reg[CS-1] ? sva_pkg::PI_FX : '0;
        else if (cz_reg[CS-1] < 0)
            zc = '0;
        else if (cz_reg[CS-1] > sva_pkg::PI_FX)
            zc = sva_pkg::PI_FX;
        else
            zc = cz_reg[CS-1];
        mag = zc[sva_pkg::OUT_SHIFT+AWD-1:sva_pkg::OUT_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (be)
            ov_reg <= cv_reg[CS-1];
    end

    always_ff @(posedge clk)
    begin
        if (be)
            ang_reg <= cneg_reg[CS-1] ? -mag : mag;
    end

endmodule
`default_nettype wire

@@ rtl/signed_vector_angle_3d_unit.sv @@
`default_nettype none
// Angle between two signed 3D vectors a and b, returned in radians as Q3.13
// (-pi..pi, truncated). Each request carries a, b and an axis vector packed in
// s_tdata (COMPONENT_BITS per component) and the axis-present flag in s_tuser.
// The front end forms exact cross and dot products, the squared cross length
// and the sign of cross.axis; a four-entry queue decouples it from the back
// end, which takes a bit-per-stage integer square root and a CORDIC vectoring
// pipeline of CORDIC_STEPS stages to get atan2(|a x b|, a.b). When axis
// present is set and cross.axis is negative, the result is negated. One
// request is accepted per clock, sustained, while the front end does not
// stall. The front end stalls only when its output is held and the queue
// is full; the back end stalls whenever its output is held.
module signed_vector_angle_3d_unit #(
    parameter int COMPONENT_BITS = sva_pkg::COMPONENT_BITS_DEF,
    parameter int CORDIC_STEPS   = sva_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          s_tvalid,
    output logic                                               s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, axis_x, axis_y, axis_z, zero fill
    input  wire logic [((9*COMPONENT_BITS+7)/8)*8-1:0]         s_tdata,
    // axis_present
    input  wire logic                                          s_tuser,
    output logic                                               m_tvalid,
    input  wire logic                                          m_tready,
    // angle
    output logic [sva_pkg::ANGLE_W-1:0]                        m_tdata
);
    localparam int N     = COMPONENT_BITS;
    localparam int DW    = 2*N + 2;
    localparam int SW    = 4*N + 2;
    localparam int QW    = SW + DW + 1;
    localparam int QDEPTH = 4;

    logic                        f_valid, f_ready, f_neg;
    logic [SW-1:0]               f_sq;
    logic signed [DW-1:0]        f_d;
    logic                        q_valid, q_ready;
    logic [QW-1:0]               q_data;
    logic signed [sva_pkg::ANGLE_W-1:0] angle;

    // front end: products, squared cross length and axis sign
    sva_front #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .a_x         ($signed(s_tdata[0*N +: N])),
        .a_y         ($signed(s_tdata[1*N +: N])),
        .a_z         ($signed(s_tdata[2*N +: N])),
        .b_x         ($signed(s_tdata[3*N +: N])),
        .b_y         ($signed(s_tdata[4*N +: N])),
        .b_z         ($signed(s_tdata[5*N +: N])),
        .axis_x      ($signed(s_tdata[6*N +: N])),
        .axis_y      ($signed(s_tdata[7*N +: N])),
        .axis_z      ($signed(s_tdata[8*N +: N])),
        .axis_present(s_tuser),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_sq      (f_sq),
        .out_d       (f_d),
        .out_neg     (f_neg)
    );

    // hold classified requests between the two halves
    sva_queue #(
        .WIDTH(QW),
        .DEPTH(QDEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(f_valid),
        .push_ready(f_ready),
        .push_data ({f_neg, f_d, f_sq}),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_data  (q_data)
    );

    // back end: square root, CORDIC, clamp and sign
    sva_back #(
        .COMPONENT_BITS(COMPONENT_BITS),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_sq    (q_data[SW-1:0]),
        .in_d     ($signed(q_data[SW+DW-1:SW])),
        .in_neg   (q_data[QW-1]),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .angle    (angle)
    );

    assign m_tdata = angle;

endmodule
`default_nettype wire

@@ dv/vector_angle_scoreboard.sv @@
module vector_angle_scoreboard (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    input  wire logic          s_tready,
    input  wire logic [143:0]  s_tdata,
    input  wire logic          s_tuser,
    input  wire logic          m_tvalid,
    input  wire logic          m_tready,
    input  wire logic [15:0]   m_tdata,
    output int                 fail_count,
    output int                 pending_count
);

    localparam longint PI_Q20      = 3294199;
    localparam longint HALF_PI_Q20 = 1647099;
    localparam int     ROT_STEPS   = 16;

    logic [15:0] expected_angles[$];
    int          request_index;
    int          result_index;

    function automatic longint rotation_angle(input int i);
        longint lut[8];
        lut = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192};
        if (i < 8)
            return lut[i];
        if (i > 20)
            return 0;
        return longint'(1) << (20 - i);
    endfunction

    function automatic logic [15:0] predict_angle(input logic [143:0] v, input logic axis_on);
        longint      ax, ay, az, bx, by, bz, vx, vy, vz;
        longint      cx, cy, cz, dot, x, y, z, t, xs, ys, ang, axis_dot;
        logic [127:0] sq, root, trial;
        int          i;
        ax = longint'($signed(v[15:0]));
        ay = longint'($signed(v[31:16]));
        az = longint'($signed(v[47:32]));
        bx = longint'($signed(v[63:48]));
        by = longint'($signed(v[79:64]));
        bz = longint'($signed(v[95:80]));
        vx = longint'($signed(v[111:96]));
        vy = longint'($signed(v[127:112]));
        vz = longint'($signed(v[143:128]));
        cx = ay * bz - az * by;
        cy = az * bx - ax * bz;
        cz = ax * by - ay * bx;
        dot = ax * bx + ay * by + az * bz;
        sq = 128'(cx * cx) + 128'(cy * cy) + 128'(cz * cz);
        // floor square root, one bit at a time
        root = '0;
        for (i = 52; i >= 0; i--)
        begin
            trial = root | (128'(1) << i);
            if (trial * trial <= sq)
                root = trial;
        end
        y = longint'(root[63:0]);
        if (y == 0)
        begin
            ang = (dot < 0) ? PI_Q20 : 0;
        end
        else
        begin
            x = dot;
            z = 0;
            // pre-rotate by pi/2 so the vectoring pass starts in the right half plane
            if (x < 0)
            begin
                t = x;
                x = y;
                y = -t;
                z = HALF_PI_Q20;
            end
            for (i = 0; i < ROT_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + rotation_angle(i);
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - rotation_angle(i);
                end
            end
            if (z < 0)
                z = 0;
            if (z > PI_Q20)
                z = PI_Q20;
            ang = z;
        end
        ang = ang >>> 7;
        axis_dot = cx * vx + cy * vy + cz * vz;
        if (axis_on && axis_dot < 0)
            ang = -ang;
        return ang[15:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH result %0d: %s", result_index, what);
        fail_count++;
    endtask

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
        request_index = 0;
        result_index  = 0;
    end

    always @(posedge clk)
    begin
        logic [15:0] exp_angle;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_angles.push_back(predict_angle(s_tdata, s_tuser));
                request_index++;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_angles.size() == 0)
                begin
                    report_mismatch("result with no request outstanding");
                end
                else
                begin
                    exp_angle = expected_angles.pop_front();
                    if (m_tdata !== exp_angle)
                        report_mismatch($sformatf("angle got %0d expected %0d",
                            $signed(m_tdata), $signed(exp_angle)));
                end
                result_index++;
            end
        end
        pending_count = expected_angles.size();
    end

endmodule

@@ dv/signed_vector_angle_3d_unit_tb.sv @@
module signed_vector_angle_3d_unit_tb;

    localparam int STALL_LIMIT  = 3000;  // cycles without any handshake
    localparam int DRAIN_CYCLES = 200;   // well past the pipeline latency
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // a_x, a_y, a_z, b_x, b_y, b_z, axis_x, axis_y, axis_z
    logic [143:0] s_tdata = '0;
    // axis_present
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // angle
    logic [15:0]  m_tdata;

    int fail_count;
    int pending_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int quiet_cycles   = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    signed_vector_angle_3d_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    vector_angle_scoreboard scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Offer one request: idle at random first, then hold valid until accepted.
    task automatic send_vectors(input logic [15:0] a[3], input logic [15:0] b[3],
                                input logic [15:0] axis[3], input logic axis_on);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {axis[2], axis[1], axis[0], b[2], b[1], b[0], a[2], a[1], a[0]};
        s_tuser  <= axis_on;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Pick a component: mostly full range, sometimes tiny or at an extreme.
    function automatic logic [15:0] pick_component();
        int kind;
        kind = $urandom_range(9);
        if (kind < 6)
            return 16'($urandom);
        if (kind < 8)
            return 16'($signed($urandom_range(6)) - 3);
        return ($urandom_range(1) != 0) ? 16'h8000 : 16'h7fff;
    endfunction

    task automatic send_random();
        logic [15:0] a[3], b[3], axis[3];
        int          k, shape;
        shape = $urandom_range(9);
        for (k = 0; k < 3; k++)
        begin
            a[k]    = pick_component();
            b[k]    = pick_component();
            axis[k] = pick_component();
        end
        // collinear pairs hit the zero-sine path
        if (shape == 0)
            b = a;
        else if (shape == 1)
            for (k = 0; k < 3; k++)
                b[k] = -a[k];
        else if (shape == 2)
            for (k = 0; k < 3; k++)
            begin
                a[k] = 16'($signed($urandom_range(200)) - 100);
                b[k] = 16'($signed(a[k]) * 3);
            end
        send_vectors(a, b, axis, 1'($urandom));
    endtask

    task automatic send_directed();
        logic [15:0] z3[3], p3[3], n3[3], ex[3], ey[3], ez[3], nz[3], mix[3];
        z3  = '{16'h0000, 16'h0000, 16'h0000};
        p3  = '{16'h7fff, 16'h7fff, 16'h7fff};
        n3  = '{16'h8000, 16'h8000, 16'h8000};
        ex  = '{16'h7fff, 16'h0000, 16'h0000};
        ey  = '{16'h0000, 16'h7fff, 16'h0000};
        ez  = '{16'h0000, 16'h0000, 16'h7fff};
        nz  = '{16'h0000, 16'h0000, 16'h8000};
        mix = '{16'h8000, 16'h7fff, 16'h0001};
        send_vectors(z3, z3, z3, 1'b0);   // both terms zero
        send_vectors(z3, p3, p3, 1'b1);
        send_vectors(p3, p3, p3, 1'b0);   // parallel
        send_vectors(p3, n3, p3, 1'b1);   // antiparallel
        send_vectors(n3, n3, n3, 1'b1);
        send_vectors(ex, ey, ez, 1'b0);   // right angle
        send_vectors(ex, ey, ez, 1'b1);   // axis agrees with cross
        send_vectors(ex, ey, nz, 1'b1);   // axis opposes cross
        send_vectors(ex, ey, ex, 1'b1);   // axis orthogonal to cross
        send_vectors(ex, ey, nz, 1'b0);   // axis ignored
        send_vectors(ey, ex, ez, 1'b1);
        send_vectors(mix, p3, n3, 1'b1);
        send_vectors(mix, n3, mix, 1'b1);
        send_vectors(n3, mix, p3, 1'b0);
        send_vectors(ex, n3, ey, 1'b1);
        send_vectors(nz, ez, p3, 1'b0);   // exact pi
        send_vectors(ex, '{16'h8001, 16'h0001, 16'h0000}, ez, 1'b1); // near pi
        send_vectors(ex, '{16'h7fff, 16'h0001, 16'h0000}, ez, 1'b1); // near zero
        send_vectors(ex, '{16'h7fff, 16'hffff, 16'h0000}, ez, 1'b1);
    endtask

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk)
    begin
        int hold_left;
        if (hold_request && hold_left == 0)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int n;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();

        for (n = 0; n < 400; n++)
            send_random();

        send_idle_pct = 57;
        for (n = 0; n < 380; n++)
            send_random();

        send_idle_pct  = 0;
        recv_stall_pct = 57;
        for (n = 0; n < 380; n++)
            send_random();

        send_idle_pct  = 9;
        recv_stall_pct = 9;
        for (n = 0; n < 380; n++)
            send_random();

        // back-pressure: hold the output while requests keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        for (n = 0; n < 360; n++)
            send_random();

        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
